@@ rtl/core/lss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } state_t;

    typedef struct packed {
        logic start;
        logic push;
        logic pop;
        logic compare;
    } cell_ctl_t;

endpackage

@@ rtl/core/lss_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry: shifts toward the bottom on push, toward the top on pop,
// and compares its word with the search key.
// ----------------------------------------------------------------------------
module lss_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  lss_pkg::cell_ctl_t ctl,
    input  lss_pkg::word_t    from_above,
    input  lss_pkg::word_t    from_below,
    input  lss_pkg::word_t    key,
    input  logic              occupied,
    output lss_pkg::word_t    data,
    output logic              match
);
    import lss_pkg::*;

    word_t data_reg;
    word_t data_next;
    logic  match_reg;
    logic  match_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.push) begin
            data_next = from_above;
        end else if (ctl.pop) begin
            data_next = from_below;
        end
    end

    always_comb begin
        match_next = match_reg;
        if (ctl.compare) begin
            match_next = occupied && (data_reg == key);
        end else if (ctl.start) begin
            match_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/core/lifo_stack_with_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of words with push, pop, peek and search.
// ----------------------------------------------------------------------------
// Each request passes through two registered steps after its input transfer:
// an execute state in which the row of cells shifts or compares every entry
// with the key, and a reduce state in which the registered match bits are
// reduced into the found flag and the result is loaded into the output
// register; the reduce state waits while that register holds an untaken result.
// A new request is accepted once the previous one has left the reduction stage,
// even while its result still waits in the output register, so only one request
// is in flight at a time. The stack holds DEPTH words, the top word in the first cell.
module lifo_stack_with_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] req_type, [33:2] value, [39:34] zero
    input  logic [lss_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] data_out, [32] found, [33] is_empty, [38:34] count,
    // [40:39] status, [47:41] zero
    output logic [lss_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lss_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    req_t      req_reg;
    word_t     key_reg;
    cnt_t      count_reg;
    cnt_t      count_next;
    word_t     res_data_reg;
    word_t     res_data_next;
    status_t   res_status_reg;
    status_t   res_status_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    word_t     out_data_reg;
    logic      out_found_reg;
    logic      out_empty_reg;
    cnt_t      out_count_reg;
    status_t   out_status_reg;
    logic      out_load;
    logic      in_xfer;
    logic      full;
    logic      empty;
    cell_ctl_t ctl;

    word_t            cell_data [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [DEPTH-1:0] cell_occ;

    assign in_xfer = s_tvalid && s_tready;
    assign full    = (count_reg == cnt_t'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        ctl.start   = in_xfer;
        ctl.push    = (state_reg == S_EXEC) && (req_reg == REQ_PUSH) && !full;
        ctl.pop     = (state_reg == S_EXEC) && (req_reg == REQ_POP) && !empty;
        ctl.compare = (state_reg == S_EXEC) && (req_reg == REQ_SEARCH);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            word_t above;
            word_t below;

            if (gi == 0) begin : g_top
                assign above = key_reg;
            end else begin : g_mid_top
                assign above = cell_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_bottom
                assign below = '0;
            end else begin : g_mid_bottom
                assign below = cell_data[gi+1];
            end

            assign cell_occ[gi] = (cnt_t'(gi) < count_reg);

            lss_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .from_above (above),
                .from_below (below),
                .key        (key_reg),
                .occupied   (cell_occ[gi]),
                .data       (cell_data[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        out_load        = 1'b0;
        s_tready        = (state_reg == S_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_data_next   = '0;
                res_status_next = ST_OK;
                unique case (req_reg)
                    REQ_PUSH: begin
                        if (full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            count_next = count_reg + cnt_t'(1);
                        end
                    end
                    REQ_POP: begin
                        if (empty) begin
                            res_data_next   = '1;
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_data_next = cell_data[0];
                            count_next    = count_reg - cnt_t'(1);
                        end
                    end
                    REQ_PEEK: begin
                        if (empty) begin
                            res_data_next   = '1;
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_data_next = cell_data[0];
                        end
                    end
                    REQ_SEARCH: begin
                    end
                    default: begin
                    end
                endcase
                state_next = S_REDUCE;
            end
            S_REDUCE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            req_reg <= req_t'(s_tdata[1:0]);
            key_reg <= s_tdata[WORD_W+1:2];
        end
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            out_data_reg   <= res_data_reg;
            out_found_reg  <= |cell_match;
            out_empty_reg  <= (count_reg == '0);
            out_count_reg  <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_status_reg, COUNT_W'(out_count_reg), out_empty_reg,
                       out_found_reg, out_data_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(DEPTH))
        else $error("stack count exceeds depth");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready ##1 !s_tready)
        else $error("request accepted while another is in flight");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("count changed outside the execute cycle");

    a_found_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_found_reg) |-> (out_status_reg == ST_OK) && !out_empty_reg)
        else $error("found flag with bad status or empty stack");

endmodule
